@@ design/rrfp_pkg.sv @@
// Shared types and constants for the radar range frame parser.
`timescale 1ns / 1ps

package rrfp_pkg;

  localparam logic [7:0] HDR_BYTE     = 8'hFE;
  localparam logic [7:0] NOTGT_BYTE   = 8'hF0;
  localparam logic [7:0] TYPE_MAX     = 8'd3;
  localparam logic [2:0] FILLER_COUNT = 3'd4;
  localparam logic [6:0] HDR_SUM      = 7'h7E;  // header byte folded to 7 bits
  localparam int         FIELD_BITS   = 16;
  localparam int         IN_BITS      = 8;
  localparam int         OUT_BITS     = 88;     // 83 payload bits padded to bytes

  typedef enum logic [2:0] {
    EV_BUSY       = 3'd0,
    EV_DISTANCE   = 3'd1,
    EV_NO_TARGET  = 3'd2,
    EV_BAD_HEADER = 3'd3,
    EV_BAD_TYPE   = 3'd4,
    EV_BAD_SUM    = 3'd5
  } event_t;

  // Packed MSB first, so event_res lands in the lowest bits.
  typedef struct packed {
    logic [FIELD_BITS-1:0] checksum_errors;
    logic [FIELD_BITS-1:0] type_errors;
    logic [FIELD_BITS-1:0] header_errors;
    logic [FIELD_BITS-1:0] no_target_total;
    logic [FIELD_BITS-1:0] range_cm;
    event_t                event_res;
  } result_t;

  localparam int RESULT_BITS = $bits(result_t);

endpackage

@@ design/rrfp_parse.sv @@
// Frame parser state machine: per-byte state update and result formation.
`timescale 1ns / 1ps

module rrfp_parse #(
  parameter int COUNTER_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  logic [7:0]           rx_byte,
  output rrfp_pkg::result_t    res
);

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_TYPE = 3'd1,
    PH_HIGH = 3'd2,
    PH_LOW  = 3'd3,
    PH_TAIL = 3'd4
  } phase_t;

  typedef logic [COUNTER_BITS-1:0] cnt_t;

  phase_t     phase, phase_next;
  logic [2:0] filler_seen, filler_seen_next;
  logic [6:0] running_sum, running_sum_next;
  logic [7:0] range_high, range_high_next;
  logic [7:0] range_low, range_low_next;
  cnt_t       no_target_count, no_target_count_next;
  cnt_t       header_error_count, header_error_count_next;
  cnt_t       type_error_count, type_error_count_next;
  cnt_t       sum_error_count, sum_error_count_next;

  rrfp_pkg::event_t                ev;
  logic [rrfp_pkg::FIELD_BITS-1:0] range_value;
  logic [31:0]                     nt_wide, he_wide, te_wide, se_wide;

  function automatic cnt_t sat_inc(input cnt_t v);
    sat_inc = (v == '1) ? v : v + cnt_t'(1);
  endfunction

  always_comb begin
    phase_next              = phase;
    filler_seen_next        = filler_seen;
    running_sum_next        = running_sum;
    range_high_next         = range_high;
    range_low_next          = range_low;
    no_target_count_next    = no_target_count;
    header_error_count_next = header_error_count;
    type_error_count_next   = type_error_count;
    sum_error_count_next    = sum_error_count;
    ev                      = rrfp_pkg::EV_BUSY;
    range_value             = '0;

    unique case (phase)
      PH_TYPE: begin
        if (rx_byte != 8'd0 && rx_byte <= rrfp_pkg::TYPE_MAX) begin
          running_sum_next = running_sum + rx_byte[6:0];
          phase_next       = PH_HIGH;
        end else begin
          phase_next            = PH_HUNT;
          type_error_count_next = sat_inc(type_error_count);
          ev                    = rrfp_pkg::EV_BAD_TYPE;
        end
      end
      PH_HIGH: begin
        range_high_next  = rx_byte;
        running_sum_next = running_sum + rx_byte[6:0];
        phase_next       = PH_LOW;
      end
      PH_LOW: begin
        range_low_next   = rx_byte;
        running_sum_next = running_sum + rx_byte[6:0];
        phase_next       = PH_TAIL;
      end
      PH_TAIL: begin
        if (filler_seen < rrfp_pkg::FILLER_COUNT) begin
          running_sum_next = running_sum + rx_byte[6:0];
          filler_seen_next = filler_seen + 3'd1;
        end else begin
          phase_next = PH_HUNT;
          // bit 7 set never matches the 7-bit sum
          if (rx_byte == {1'b0, running_sum}) begin
            range_value = rrfp_pkg::FIELD_BITS'({range_high, 7'b0})
                        + rrfp_pkg::FIELD_BITS'(range_low);
            ev          = rrfp_pkg::EV_DISTANCE;
          end else begin
            sum_error_count_next = sat_inc(sum_error_count);
            ev                   = rrfp_pkg::EV_BAD_SUM;
          end
        end
      end
      default: begin
        // hunting; unused phase codes behave the same
        phase_next = PH_HUNT;
        if (rx_byte == rrfp_pkg::HDR_BYTE) begin
          header_error_count_next = '0;
          type_error_count_next   = '0;
          sum_error_count_next    = '0;
          filler_seen_next        = '0;
          range_high_next         = '0;
          range_low_next          = '0;
          running_sum_next        = rrfp_pkg::HDR_SUM;
          phase_next              = PH_TYPE;
        end else if (rx_byte == rrfp_pkg::NOTGT_BYTE) begin
          no_target_count_next = sat_inc(no_target_count);
          ev                   = rrfp_pkg::EV_NO_TARGET;
        end else begin
          header_error_count_next = sat_inc(header_error_count);
          ev                      = rrfp_pkg::EV_BAD_HEADER;
        end
      end
    endcase
  end

  // counts leave the block as 16-bit fields
  assign nt_wide = 32'(no_target_count_next);
  assign he_wide = 32'(header_error_count_next);
  assign te_wide = 32'(type_error_count_next);
  assign se_wide = 32'(sum_error_count_next);

  always_comb begin
    res.event_res       = ev;
    res.range_cm        = range_value;
    res.no_target_total = nt_wide[rrfp_pkg::FIELD_BITS-1:0];
    res.header_errors   = he_wide[rrfp_pkg::FIELD_BITS-1:0];
    res.type_errors     = te_wide[rrfp_pkg::FIELD_BITS-1:0];
    res.checksum_errors = se_wide[rrfp_pkg::FIELD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_HUNT;
      filler_seen        <= '0;
      running_sum        <= '0;
      range_high         <= '0;
      range_low          <= '0;
      no_target_count    <= '0;
      header_error_count <= '0;
      type_error_count   <= '0;
      sum_error_count    <= '0;
    end else if (in_fire) begin
      phase              <= phase_next;
      filler_seen        <= filler_seen_next;
      running_sum        <= running_sum_next;
      range_high         <= range_high_next;
      range_low          <= range_low_next;
      no_target_count    <= no_target_count_next;
      header_error_count <= header_error_count_next;
      type_error_count   <= type_error_count_next;
      sum_error_count    <= sum_error_count_next;
    end
  end

  a_hdr_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && phase == PH_HUNT && rx_byte == rrfp_pkg::HDR_BYTE |=>
      header_error_count == '0 && type_error_count == '0 && sum_error_count == '0
      && phase == PH_TYPE && running_sum == rrfp_pkg::HDR_SUM)
    else $error("header did not restart the frame");

  a_filler_stays: assert property (@(posedge clk) disable iff (rst)
    in_fire && phase == PH_TAIL && filler_seen < rrfp_pkg::FILLER_COUNT |=>
      phase == PH_TAIL && filler_seen == $past(filler_seen) + 3'd1)
    else $error("filler byte left the tail phase");

  a_dist_only_good: assert property (@(posedge clk) disable iff (rst)
    res.event_res != rrfp_pkg::EV_DISTANCE |-> res.range_cm == '0)
    else $error("range reported without a good frame");

endmodule

@@ design/rrfp_skid.sv @@
// Two-entry output stage: result register plus skid register.
`timescale 1ns / 1ps

module rrfp_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rrfp_pkg::result_t push_data,
  output logic              push_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output rrfp_pkg::result_t out_data
);

  logic              skid_valid;
  rrfp_pkg::result_t skid_data;
  logic              pop;

  assign pop        = out_valid && out_ready;
  assign push_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end else if (push) begin
          out_data <= push_data;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (push) begin
        if (out_valid) begin
          skid_data  <= push_data;
          skid_valid <= 1'b1;
        end else begin
          out_data  <= push_data;
          out_valid <= 1'b1;
        end
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    push && out_valid && !out_ready |=> skid_valid && skid_data == $past(push_data))
    else $error("beat lost during output stall");

  a_push_when_room: assert property (@(posedge clk) disable iff (rst)
    push |-> push_ready)
    else $error("beat pushed into a full stage");

endmodule

@@ design/radar_range_frame_parser.sv @@
// Top level of the radar range frame parser: byte in, one result beat out.
`timescale 1ns / 1ps
//
//  channel  | dir | handshake                   | tdata fields (low bit up)
//  ---------+-----+-----------------------------+-----------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready | rx_byte[7:0]
//  m_axis   | out | m_axis_tvalid/m_axis_tready | event_res[2:0], range_cm[18:3],
//           |     |                             | no_target_total[34:19],
//           |     |                             | header_errors[50:35],
//           |     |                             | type_errors[66:51],
//           |     |                             | checksum_errors[82:67], zero pad
//
//  One byte per cycle while s_axis_tready is high, one result beat per byte. A
//  result is registered as its byte is taken, in the edge where the parser state
//  and counters update, so bytes flow with no bubbles while the skid has room.
//  Reset (rst, synchronous) puts the parser in header hunt with all counts
//  zero and empties the output stage.
//  Output stalls are absorbed by a one-beat skid register; s_axis_tready
//  drops only when both the result and skid registers are full.

module radar_range_frame_parser #(
  parameter int COUNTER_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rrfp_pkg::IN_BITS-1:0]  s_axis_tdata,  // rx_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // event_res, range_cm, no_target_total, header_errors, type_errors,
  // checksum_errors, then zero fill
  output logic [rrfp_pkg::OUT_BITS-1:0] m_axis_tdata
);

  logic              in_fire;
  rrfp_pkg::result_t step_res;
  rrfp_pkg::result_t out_res;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  // parser state advances only on an accepted byte
  rrfp_parse #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_parse (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .rx_byte (s_axis_tdata),
    .res     (step_res)
  );

  rrfp_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push       (in_fire),
    .push_data  (step_res),
    .push_ready (s_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (out_res)
  );

  assign m_axis_tdata = rrfp_pkg::OUT_BITS'(out_res);

endmodule
